/* rtl/core/bte_pkg.sv */
// Shared types, widths and glyph decode helpers for the bitmap text pixel emitter.
// No dependencies.
package bte_pkg;

    localparam int MAX_COLUMNS = 256;
    localparam int COL_W       = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;

    localparam int CODE_W   = 8;
    localparam int ORG_W    = 12;
    localparam int SCALE_W  = 4;
    localparam int X_W      = 16;
    localparam int Y_W      = 13;
    localparam int ROW_W    = 3;
    localparam int BITS_W   = 8;
    localparam int GLYPH_COUNT = 36;
    localparam int GLYPH_W  = $clog2(GLYPH_COUNT);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_SCALE = 2'd2;

    typedef struct packed {
        logic [ORG_W-1:0]   origin_x;
        logic [ORG_W-1:0]   origin_y;
        logic [SCALE_W-1:0] scale;      // effective scale, never zero
    } cfg_t;

    typedef struct packed {
        logic               en;
        logic [GLYPH_W-1:0] glyph;
        logic [ROW_W-1:0]   row;
    } rom_req_t;

    typedef struct packed {
        logic               hit;
        logic [GLYPH_W-1:0] idx;
    } glyph_sel_t;

    // Case fold, then map A-Z to 0..25 and 0-9 to 26..35; anything else misses.
    function automatic glyph_sel_t glyph_decode(input logic [CODE_W-1:0] code);
        logic [CODE_W-1:0] c;
        glyph_sel_t        sel;
        c = code;
        sel.hit = 1'b0;
        sel.idx = '0;
        if (c >= 8'h61 && c <= 8'h7A) c = c - 8'd32;
        if (c >= 8'h41 && c <= 8'h5A) begin
            sel.hit = 1'b1;
            sel.idx = GLYPH_W'(c - 8'h41);
        end else if (c >= 8'h30 && c <= 8'h39) begin
            sel.hit = 1'b1;
            sel.idx = GLYPH_W'(c - 8'h30 + 8'd26);
        end
        return sel;
    endfunction

    // Scan position {row, col} of the final set bit of each glyph.
    function automatic logic [ROW_W+2:0] last_pos(input logic [GLYPH_W-1:0] idx);
        logic [ROW_W+2:0] p;
        case (idx)
            6'd0:  p = 6'd54;
            6'd1:  p = 6'd52;
            6'd2:  p = 6'd53;
            6'd3:  p = 6'd52;
            6'd4:  p = 6'd52;
            6'd5:  p = 6'd48;
            6'd6:  p = 6'd53;
            6'd7:  p = 6'd53;
            6'd8:  p = 6'd53;
            6'd9:  p = 6'd53;
            6'd10: p = 6'd53;
            6'd11: p = 6'd52;
            6'd12: p = 6'd53;
            6'd13: p = 6'd53;
            6'd14: p = 6'd53;
            6'd15: p = 6'd48;
            6'd16: p = 6'd63;
            6'd17: p = 6'd53;
            6'd18: p = 6'd53;
            6'd19: p = 6'd52;
            6'd20: p = 6'd53;
            6'd21: p = 6'd53;
            6'd22: p = 6'd53;
            6'd23: p = 6'd55;
            6'd24: p = 6'd52;
            6'd25: p = 6'd54;
            6'd26: p = 6'd53;
            6'd27: p = 6'd54;
            6'd28: p = 6'd54;
            6'd29: p = 6'd53;
            6'd30: p = 6'd53;
            6'd31: p = 6'd53;
            6'd32: p = 6'd53;
            6'd33: p = 6'd49;
            6'd34: p = 6'd53;
            6'd35: p = 6'd53;
            default: p = '1;
        endcase
        return p;
    endfunction

endpackage

/* rtl/core/bitmap_text_pixel_emitter.sv */
// Top level of the bitmap text pixel emitter: configuration registers and unit hookup.
// Depends on bte_pkg, bte_glyph_rom, bte_scan.
//
//  channel  | ports           | tdata (low bit up)                    | tuser / tlast
//  ---------+-----------------+---------------------------------------+-------------------
//  input    | s_tvalid/tready | char_code[7:0]                        | tuser: start_of_text
//  output   | m_tvalid/tready | block_x[15:0] block_y[28:16] size[32:29] | tlast: last_of_char
//  config   | cfg_wr_*        | 0 origin_x, 1 origin_y, 2 pixel_scale | -
//
// A glyph character is accepted, then its first ROM row is loaded, then it is scanned
// glyph bit by glyph bit; each later row is read from the glyph ROM a row ahead, so it
// is waiting when the current row ends. Blank and unknown codes are accepted without a scan.
// Output stalls hold the scan only on set bits. Reset is synchronous, active low;
// pixel_scale resets to 1 and a written 0 acts as 1.
module bitmap_text_pixel_emitter (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [bte_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  logic [bte_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // [7:0] char_code
    input  logic [0:0]                        s_tuser,   // [0] start_of_text
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [39:0]                       m_tdata,   // [15:0] x, [28:16] y, [32:29] size
    output logic                              m_tlast    // last_of_char
);
    import bte_pkg::*;

    logic [ORG_W-1:0]   origin_x_reg;
    logic [ORG_W-1:0]   origin_y_reg;
    logic [SCALE_W-1:0] scale_reg;
    cfg_t               cfg;
    rom_req_t           rom_req;
    logic [BITS_W-1:0]  rom_data;
    logic [X_W-1:0]     block_x;
    logic [Y_W-1:0]     block_y;
    logic [SCALE_W-1:0] block_size;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            scale_reg    <= SCALE_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_ORIGIN_X:    origin_x_reg <= cfg_wr_data[ORG_W-1:0];
                REG_ORIGIN_Y:    origin_y_reg <= cfg_wr_data[ORG_W-1:0];
                REG_PIXEL_SCALE: scale_reg    <= cfg_wr_data[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.origin_x = origin_x_reg;
    assign cfg.origin_y = origin_y_reg;
    assign cfg.scale    = (scale_reg == '0) ? SCALE_W'(1) : scale_reg;

    bte_glyph_rom u_rom (
        .aclk    (aclk),
        .req     (rom_req),
        .rd_data (rom_data)
    );

    bte_scan u_scan (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .char_code     (s_tdata[CODE_W-1:0]),
        .start_of_text (s_tuser[0]),
        .rom_req       (rom_req),
        .rom_data      (rom_data),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .block_x       (block_x),
        .block_y       (block_y),
        .block_size    (block_size),
        .last_of_char  (m_tlast)
    );

    assign m_tdata = {7'd0, block_size, block_y, block_x};

endmodule

/* rtl/core/bte_glyph_rom.sv */
// Synchronous 8x8 glyph ROM, one row per read; the row is registered.
// Depends on bte_pkg.
module bte_glyph_rom (
    input  logic                        aclk,
    input  bte_pkg::rom_req_t           req,
    output logic [bte_pkg::BITS_W-1:0]  rd_data
);
    import bte_pkg::*;

    // Row 0 in the top byte, bit 7 of a row is the leftmost pixel.
    localparam logic [63:0] GLYPHS [GLYPH_COUNT] = '{
        64'h3C66427E42424200, 64'hF88484F88484F800, 64'h3C42404040423C00,
        64'hF88484848484F800, 64'hF88080F08080F800, 64'hF88080F080808000,
        64'h7C8080BE82827C00, 64'h848484FE84848400, 64'h3C10101010103C00,
        64'h3C08080808887C00, 64'h8488B0C0B0888400, 64'h808080808080F800,
        64'h84C6A6A6A6848400, 64'h84C4A4948C868400, 64'h7C82828282827C00,
        64'hF88484F880808000, 64'h7C8282BE82827E01, 64'hF88484F888848400,
        64'h7C82807C02017C00, 64'hFC08080808080800, 64'h8484848484847C00,
        64'h8484848484847C00, 64'h8484A4A4A4848400, 64'h8142241824428100,
        64'h8484847C08080800, 64'hFE0408102040FE00, 64'h7C82929292827C00,
        64'h081828080808_3E00, 64'h7C82021C2040FE00, 64'h7C82023C02827C00,
        64'h0C142444FE040400, 64'hFE8080FC02827C00, 64'h7C8280FC82827C00,
        64'hFE02040810204000, 64'h7C82827C82827C00, 64'h7C82827E02827C00
    };

    logic [63:0] glyph_word;

    assign glyph_word = (req.glyph < GLYPH_W'(GLYPH_COUNT)) ? GLYPHS[req.glyph] : '0;

    always_ff @(posedge aclk) begin
        if (req.en) begin
            rd_data <= glyph_word[63 - 8 * req.row -: 8];
        end
    end

endmodule

/* rtl/core/bte_scan.sv */
// Glyph scan sequencer: column tracking, ROM row fetch, block coordinates, output register.
// Depends on bte_pkg; drives bte_glyph_rom.
module bte_scan (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  bte_pkg::cfg_t                 cfg,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bte_pkg::CODE_W-1:0]    char_code,
    input  logic                          start_of_text,
    output bte_pkg::rom_req_t             rom_req,
    input  logic [bte_pkg::BITS_W-1:0]    rom_data,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bte_pkg::X_W-1:0]       block_x,
    output logic [bte_pkg::Y_W-1:0]       block_y,
    output logic [bte_pkg::SCALE_W-1:0]   block_size,
    output logic                          last_of_char
);
    import bte_pkg::*;

    typedef enum logic [1:0] {IDLE, LOAD, SCAN} state_t;

    state_t               state_reg;
    logic [COL_W-1:0]     column_reg;
    logic [GLYPH_W-1:0]   glyph_reg;
    logic [ROW_W-1:0]     row_reg;
    logic [2:0]           col_reg;
    logic [BITS_W-1:0]    bits_reg;
    logic [X_W-1:0]       base_x_reg;
    logic [X_W-1:0]       x_reg;
    logic [Y_W-1:0]       y_reg;
    logic                 m_valid_reg;
    logic [X_W-1:0]       m_x_reg;
    logic [Y_W-1:0]       m_y_reg;
    logic [SCALE_W-1:0]   m_size_reg;
    logic                 m_last_reg;

    glyph_sel_t           sel;
    logic                 accept;
    logic [COL_W-1:0]     column_eff;
    logic [COL_W-1:0]     column_next;
    logic [COL_W+SCALE_W-1:0] col_prod;
    logic [COL_W+SCALE_W+2:0] col_off;
    logic [X_W-1:0]       base_x_next;
    logic                 out_free;
    logic                 pix_bit;
    logic                 step;
    logic                 load_out;
    logic                 row_end;

    assign sel        = glyph_decode(char_code);
    assign s_tready   = (state_reg == IDLE);
    assign accept     = s_tvalid && s_tready;
    assign column_eff = start_of_text ? '0 : column_reg;
    assign column_next = (32'(column_eff) < MAX_COLUMNS - 1) ? column_eff + 1'b1 : column_eff;
    assign col_prod   = column_eff * cfg.scale;
    assign col_off    = {col_prod, 3'b000};
    assign base_x_next = X_W'(cfg.origin_x) + X_W'(col_off);

    assign out_free = !m_valid_reg || m_tready;
    assign pix_bit  = bits_reg[3'd7 - col_reg];
    assign step     = (state_reg == SCAN) && (!pix_bit || out_free);
    assign load_out = step && pix_bit;
    assign row_end  = step && (col_reg == 3'd7);

    always_comb begin
        rom_req.en    = 1'b0;
        rom_req.glyph = glyph_reg;
        rom_req.row   = row_reg + 3'd2;  // next-but-one row; wrap past row 7 is never used
        case (state_reg)
            IDLE: begin
                rom_req.en    = accept;
                rom_req.glyph = sel.idx;
                rom_req.row   = '0;
            end
            LOAD: begin
                rom_req.en  = 1'b1;
                rom_req.row = 3'd1;
            end
            SCAN:    rom_req.en = row_end;
            default: rom_req.en = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= IDLE;
            column_reg  <= '0;
            row_reg     <= '0;
            col_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load_out) begin
                m_valid_reg <= 1'b1;
                m_x_reg     <= x_reg;
                m_y_reg     <= y_reg;
                m_size_reg  <= cfg.scale;
                m_last_reg  <= ({row_reg, col_reg} == last_pos(glyph_reg));
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE: begin
                    if (accept) begin
                        column_reg <= column_next;
                        glyph_reg  <= sel.idx;
                        base_x_reg <= base_x_next;
                        x_reg      <= base_x_next;
                        y_reg      <= Y_W'(cfg.origin_y);
                        if (sel.hit) state_reg <= LOAD;
                    end
                end
                LOAD: begin
                    bits_reg  <= rom_data;
                    state_reg <= SCAN;
                end
                SCAN: begin
                    if (step) begin
                        col_reg <= col_reg + 3'd1;
                    end
                    if (row_end) begin
                        row_reg  <= row_reg + 3'd1;
                        x_reg    <= base_x_reg;
                        y_reg    <= y_reg + Y_W'(cfg.scale);
                        bits_reg <= rom_data;
                        if (row_reg == 3'd7) state_reg <= IDLE;
                    end else if (step) begin
                        x_reg <= x_reg + X_W'(cfg.scale);
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    assign m_tvalid     = m_valid_reg;
    assign block_x      = m_x_reg;
    assign block_y      = m_y_reg;
    assign block_size   = m_size_reg;
    assign last_of_char = m_last_reg;

`ifndef ASSERT_OFF
    a_idle_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == IDLE |-> row_reg == '0 && col_reg == '0)
        else $error("scan position not cleared between characters");
    a_load_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == LOAD |=> state_reg == SCAN)
        else $error("first row load did not enter scan");
    a_last_row: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out && ({row_reg, col_reg} == last_pos(glyph_reg)) |-> row_reg >= 3'd6)
        else $error("final block flagged too early in the glyph");
    a_no_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> out_free)
        else $error("block written over a pending transaction");
`endif

endmodule
